### design/nnfs_pkg.sv
// Shared types, constants and register indexes for the nearest-neighbor fit scaler.
`timescale 1ns / 1ps

package nnfs_pkg;

    // Default coordinate width; the top level hands it down as COORD_BITS
    localparam int COORD_BITS_DEFAULT = 12;

    // Fixed field widths
    localparam int CHANNEL_BITS     = 8;
    localparam int PIXEL_BITS       = 3 * CHANNEL_BITS;
    localparam int S_TDATA_BITS     = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS        = 24;
    localparam int COLOR_BITS       = 24;
    localparam int RED_SHIFT        = 16;
    localparam int GREEN_SHIFT      = 8;
    localparam int CFG_INDEX_BITS   = 4;

    // Geometry constants: 2-pixel border on each side, smallest usable window
    localparam int BORDER_TOTAL     = 4;
    localparam int MIN_WINDOW       = 5;

    // Register reset values
    localparam int IMAGE_WIDTH_RESET   = 1;
    localparam int IMAGE_HEIGHT_RESET  = 1;
    localparam int WINDOW_WIDTH_RESET  = 780;
    localparam int WINDOW_HEIGHT_RESET = 560;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_WIDTH  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HEIGHT = 4'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_SETUP,
        ST_DIV,
        ST_FINISH,
        ST_HELD
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_pixel;   // latch the frame's first pixel
        logic geom_mul;     // form the two cross products
        logic geom_setup;   // pick the limiting side, load the divider
        logic div_step;     // one restoring division step
        logic geom_finish;  // latch drawn size and origin
        logic process;      // run one pixel through selection and counters
        logic use_held;     // color comes from the latched pixel
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_start;  // next pixel is the first of a frame
        logic out_free;     // result register can take a beat this cycle
        logic div_done;     // divider has finished all steps
    } dp_status_t;

endpackage

### design/nnfs_ctrl.sv
// Controller state machine: frame-start geometry sequence and pixel flow.
`timescale 1ns / 1ps

module nnfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  nnfs_pkg::dp_status_t status,
    output nnfs_pkg::ctrl_cmd_t  cmd
);
    import nnfs_pkg::*;

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_tvalid && status.frame_start) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_HELD;
            ST_HELD: begin
                if (status.out_free) begin
                    state_next = ST_RUN;
                end
            end
            default:   state_next = ST_RUN;
        endcase
    end

    // Outputs
    always_comb begin
        logic ready;
        ready    = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_RUN: begin
                // first pixel of a frame is only latched, so no output slot needed
                ready = status.frame_start | status.out_free;
                if (s_tvalid && ready) begin
                    if (status.frame_start) begin
                        cmd.take_pixel = 1'b1;
                    end else begin
                        cmd.process = 1'b1;
                    end
                end
            end
            ST_MUL:    cmd.geom_mul = 1'b1;
            ST_SETUP:  cmd.geom_setup = 1'b1;
            ST_DIV:    cmd.div_step = !status.div_done;
            ST_FINISH: cmd.geom_finish = 1'b1;
            ST_HELD: begin
                if (status.out_free) begin
                    cmd.process  = 1'b1;
                    cmd.use_held = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
        s_tready = ready;
    end

endmodule

### design/nnfs_datapath.sv
// Datapath: config registers, geometry divider, sampling counters, result register.
`timescale 1ns / 1ps

module nnfs_datapath #(
    parameter int COORD_BITS = nnfs_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nnfs_pkg::ctrl_cmd_t                 cmd,
    output nnfs_pkg::dp_status_t                status,
    input  logic                                cfg_write,
    input  logic [nnfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic [nnfs_pkg::PIXEL_BITS-1:0]     s_pixel,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [COORD_BITS-1:0]               m_dest_x,
    output logic [COORD_BITS-1:0]               m_dest_y,
    output logic [nnfs_pkg::ADDR_BITS-1:0]      m_dest_address,
    output logic [nnfs_pkg::COLOR_BITS-1:0]     m_pixel_color
);
    import nnfs_pkg::*;

    localparam int PROD_BITS      = 2 * COORD_BITS;
    localparam int ADDR_FULL_BITS = PROD_BITS + 1;
    localparam int DIV_STEPS      = PROD_BITS;
    localparam int CNT_BITS       = $clog2(DIV_STEPS + 1);

    // Configuration registers
    logic [COORD_BITS-1:0] image_width_reg, image_height_reg;
    logic [COORD_BITS-1:0] window_width_reg, window_height_reg;

    // Frame geometry
    logic [COORD_BITS-1:0] drawn_width_reg, drawn_width_next;
    logic [COORD_BITS-1:0] drawn_height_reg, drawn_height_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;

    // Sampling counters
    logic [COORD_BITS-1:0] source_column_reg, source_column_next;
    logic [COORD_BITS-1:0] source_row_reg, source_row_next;
    logic [COORD_BITS-1:0] output_column_reg, output_column_next;
    logic [COORD_BITS-1:0] output_row_reg, output_row_next;
    logic [PROD_BITS-1:0]  col_target_reg, col_target_next;
    logic [PROD_BITS-1:0]  row_target_reg, row_target_next;
    // (source index + 1) * drawn size, kept by addition
    logic [PROD_BITS-1:0]  col_bound_reg, col_bound_next;
    logic [PROD_BITS-1:0]  row_bound_reg, row_bound_next;

    // Geometry divider
    logic [PROD_BITS-1:0]  prod_a_reg, prod_b_reg;
    logic                  width_limited_reg;
    logic [PROD_BITS-1:0]  quotient_reg;
    logic [COORD_BITS-1:0] remainder_reg;
    logic [COORD_BITS-1:0] divisor_reg;
    logic [CNT_BITS-1:0]   div_count_reg;

    // Held pixel and result register
    logic [PIXEL_BITS-1:0] held_pixel_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [COORD_BITS-1:0] dest_x_reg, dest_y_reg;
    logic [ADDR_BITS-1:0]  dest_address_reg;
    logic [COLOR_BITS-1:0] pixel_color_reg;

    logic                  out_free;
    logic                  load_result;

    // Geometry terms
    logic [COORD_BITS-1:0] avail_w, avail_h;
    logic                  zero_size, fits;
    logic [COORD_BITS-1:0] dw_calc, dh_calc;

    assign avail_w   = window_width_reg - COORD_BITS'(BORDER_TOTAL);
    assign avail_h   = window_height_reg - COORD_BITS'(BORDER_TOTAL);
    assign zero_size = (image_width_reg == '0) || (image_height_reg == '0) ||
                       (window_width_reg < COORD_BITS'(MIN_WINDOW)) ||
                       (window_height_reg < COORD_BITS'(MIN_WINDOW));
    assign fits      = (image_width_reg <= avail_w) && (image_height_reg <= avail_h);

    // Drawn size: zero for a degenerate setup, the image size if it fits, else from the divider result
    always_comb begin
        if (zero_size) begin
            dw_calc = '0;
            dh_calc = '0;
        end else if (fits) begin
            dw_calc = image_width_reg;
            dh_calc = image_height_reg;
        end else if (width_limited_reg) begin
            dw_calc = avail_w;
            dh_calc = quotient_reg[COORD_BITS-1:0];
        end else begin
            dw_calc = quotient_reg[COORD_BITS-1:0];
            dh_calc = avail_h;
        end
    end

    // Restoring divider step
    logic [COORD_BITS:0]   div_shift;
    logic                  div_bit;
    assign div_shift = {remainder_reg, quotient_reg[PROD_BITS-1]};
    assign div_bit   = div_shift >= {1'b0, divisor_reg};

    // Pixel selection
    logic                  row_sel, col_sel, sel;
    logic [COORD_BITS-1:0] dx, dy;
    logic [ADDR_FULL_BITS-1:0] addr_full;
    logic [PIXEL_BITS-1:0] pixel;
    logic [COORD_BITS:0]   col_plus, row_plus;
    logic                  col_wrap, row_wrap;

    assign row_sel = (drawn_width_reg != '0) && (drawn_height_reg != '0) &&
                     (output_row_reg < drawn_height_reg) &&
                     (row_target_reg < row_bound_reg);
    assign col_sel = (output_column_reg < drawn_width_reg) &&
                     (col_target_reg < col_bound_reg);
    assign sel     = row_sel && col_sel;

    assign dx        = origin_x_reg + output_column_reg;
    assign dy        = origin_y_reg + drawn_height_reg - COORD_BITS'(1) - output_row_reg;
    assign addr_full = ADDR_FULL_BITS'(dy) * ADDR_FULL_BITS'(window_width_reg) +
                       ADDR_FULL_BITS'(dx);
    assign pixel     = cmd.use_held ? held_pixel_reg : s_pixel;

    assign col_plus = {1'b0, source_column_reg} + (COORD_BITS + 1)'(1);
    assign row_plus = {1'b0, source_row_reg} + (COORD_BITS + 1)'(1);
    assign col_wrap = col_plus >= {1'b0, image_width_reg};
    assign row_wrap = row_plus >= {1'b0, image_height_reg};

    assign out_free    = !m_tvalid_reg || m_tready;
    assign load_result = cmd.process && sel;

    // Counter and geometry next state
    always_comb begin
        drawn_width_next   = drawn_width_reg;
        drawn_height_next  = drawn_height_reg;
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        source_column_next = source_column_reg;
        source_row_next    = source_row_reg;
        output_column_next = output_column_reg;
        output_row_next    = output_row_reg;
        col_target_next    = col_target_reg;
        row_target_next    = row_target_reg;
        col_bound_next     = col_bound_reg;
        row_bound_next     = row_bound_reg;

        if (cmd.geom_finish) begin
            drawn_width_next  = dw_calc;
            drawn_height_next = dh_calc;
            if (dw_calc == '0 || dh_calc == '0) begin
                origin_x_next = '0;
                origin_y_next = '0;
            end else begin
                origin_x_next = (window_width_reg - dw_calc) >> 1;
                origin_y_next = (window_height_reg - dh_calc) >> 1;
            end
            col_bound_next = PROD_BITS'(dw_calc);
            row_bound_next = PROD_BITS'(dh_calc);
        end

        if (cmd.process) begin
            if (sel) begin
                output_column_next = output_column_reg + COORD_BITS'(1);
                col_target_next    = col_target_reg + PROD_BITS'(image_width_reg);
            end
            if (col_wrap) begin
                source_column_next = '0;
                output_column_next = '0;
                col_target_next    = '0;
                col_bound_next     = PROD_BITS'(drawn_width_reg);
                if (row_sel) begin
                    output_row_next = output_row_reg + COORD_BITS'(1);
                    row_target_next = row_target_reg + PROD_BITS'(image_height_reg);
                end
                if (row_wrap) begin
                    source_row_next = '0;
                    output_row_next = '0;
                    row_target_next = '0;
                    row_bound_next  = PROD_BITS'(drawn_height_reg);
                end else begin
                    source_row_next = row_plus[COORD_BITS-1:0];
                    row_bound_next  = row_bound_reg + PROD_BITS'(drawn_height_reg);
                end
            end else begin
                source_column_next = col_plus[COORD_BITS-1:0];
                col_bound_next     = col_bound_reg + PROD_BITS'(drawn_width_reg);
            end
        end
    end

    // Result valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= COORD_BITS'(IMAGE_WIDTH_RESET);
            image_height_reg  <= COORD_BITS'(IMAGE_HEIGHT_RESET);
            window_width_reg  <= COORD_BITS'(WINDOW_WIDTH_RESET);
            window_height_reg <= COORD_BITS'(WINDOW_HEIGHT_RESET);
            drawn_width_reg   <= '0;
            drawn_height_reg  <= '0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            source_column_reg <= '0;
            source_row_reg    <= '0;
            output_column_reg <= '0;
            output_row_reg    <= '0;
            col_target_reg    <= '0;
            row_target_reg    <= '0;
            col_bound_reg     <= '0;
            row_bound_reg     <= '0;
            div_count_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                    REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                    REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                    REG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            drawn_width_reg   <= drawn_width_next;
            drawn_height_reg  <= drawn_height_next;
            origin_x_reg      <= origin_x_next;
            origin_y_reg      <= origin_y_next;
            source_column_reg <= source_column_next;
            source_row_reg    <= source_row_next;
            output_column_reg <= output_column_next;
            output_row_reg    <= output_row_next;
            col_target_reg    <= col_target_next;
            row_target_reg    <= row_target_next;
            col_bound_reg     <= col_bound_next;
            row_bound_reg     <= row_bound_next;
            if (cmd.geom_setup) begin
                div_count_reg <= '0;
            end else if (cmd.div_step) begin
                div_count_reg <= div_count_reg + CNT_BITS'(1);
            end
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // Payload registers: held pixel, products, divider, result
    always_ff @(posedge aclk) begin
        if (cmd.take_pixel) begin
            held_pixel_reg <= s_pixel;
        end
        if (cmd.geom_mul) begin
            prod_a_reg <= PROD_BITS'(avail_w) * PROD_BITS'(image_height_reg);
            prod_b_reg <= PROD_BITS'(avail_h) * PROD_BITS'(image_width_reg);
        end
        if (cmd.geom_setup) begin
            // width is the limit when aw*h < ah*w: dh = h*aw / w, else dw = w*ah / h
            width_limited_reg <= prod_a_reg < prod_b_reg;
            quotient_reg      <= (prod_a_reg < prod_b_reg) ? prod_a_reg : prod_b_reg;
            divisor_reg       <= (prod_a_reg < prod_b_reg) ? image_width_reg
                                                           : image_height_reg;
            remainder_reg     <= '0;
        end else if (cmd.div_step) begin
            quotient_reg  <= {quotient_reg[PROD_BITS-2:0], div_bit};
            remainder_reg <= div_bit ? COORD_BITS'(div_shift - {1'b0, divisor_reg})
                                     : div_shift[COORD_BITS-1:0];
        end
        if (load_result) begin
            dest_x_reg       <= dx;
            dest_y_reg       <= dy;
            dest_address_reg <= ADDR_BITS'(addr_full);
            pixel_color_reg  <= COLOR_BITS'(pixel[CHANNEL_BITS-1:0]) << RED_SHIFT |
                                COLOR_BITS'(pixel[2*CHANNEL_BITS-1:CHANNEL_BITS])
                                    << GREEN_SHIFT |
                                COLOR_BITS'(pixel[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
        end
    end

    assign status.frame_start = (source_column_reg == '0) && (source_row_reg == '0);
    assign status.out_free    = out_free;
    assign status.div_done    = div_count_reg == CNT_BITS'(DIV_STEPS);

    assign m_tvalid       = m_tvalid_reg;
    assign m_dest_x       = dest_x_reg;
    assign m_dest_y       = dest_y_reg;
    assign m_dest_address = dest_address_reg;
    assign m_pixel_color  = pixel_color_reg;

    // Drawn column never runs past the drawn width
    a_column_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        output_column_reg <= drawn_width_reg)
        else $error("output column beyond drawn width");

    // Drawn row never runs past the drawn height
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        output_row_reg <= drawn_height_reg)
        else $error("output row beyond drawn height");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> out_free)
        else $error("result register overwritten");

    // Geometry is latched only with the source and output counters at the frame origin
    a_geom_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.geom_finish |-> (status.frame_start && output_column_reg == '0 &&
                             output_row_reg == '0))
        else $error("geometry latched mid-frame");

endmodule

### design/nearest_neighbor_fit_scaler.sv
// Top level of the nearest-neighbor fit scaler: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Takes RGB pixels in raster order and emits one frame-buffer write beat for every
// pixel that nearest-neighbor sampling keeps, shrinking the image to fit the window
// less a 2-pixel border, centered and flipped vertically. A pixel that is not kept
// produces no beat. Outside a frame's first pixel, one pixel is taken per cycle as
// long as the result register is free or being drained. Before the next pixel is
// accepted, the first pixel of each frame passes through its own accept, the cross
// products, a setup, the bit-serial restoring divider that sizes the limiting side
// (2*COORD_BITS steps plus a done check), the geometry latch and the held pixel's
// own pass, which waits for a free result register. Configuration writes are always
// taken, but must only be issued while the block is idle.
module nearest_neighbor_fit_scaler #(
    parameter int COORD_BITS = nnfs_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    // Source pixels
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields, low to high: red[7:0], green[15:8], blue[23:16]
    input  logic [nnfs_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // Frame-buffer writes
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields, low to high: dest_x, dest_y, dest_address (24), pixel_color (24)
    output logic [((2*COORD_BITS + nnfs_pkg::ADDR_BITS + nnfs_pkg::COLOR_BITS + 7)
                   / 8) * 8 - 1:0]              m_tdata
);
    import nnfs_pkg::*;

    localparam int M_TDATA_BITS = ((2*COORD_BITS + ADDR_BITS + COLOR_BITS + 7) / 8) * 8;

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic [COORD_BITS-1:0] dest_x, dest_y;
    logic [ADDR_BITS-1:0]  dest_address;
    logic [COLOR_BITS-1:0] pixel_color;

    // Registers always take a write
    assign cfg_ready = 1'b1;

    nnfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nnfs_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_pixel        (s_tdata[PIXEL_BITS-1:0]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_dest_x       (dest_x),
        .m_dest_y       (dest_y),
        .m_dest_address (dest_address),
        .m_pixel_color  (pixel_color)
    );

    // Pack the result beat, zero-filled to whole bytes
    assign m_tdata = M_TDATA_BITS'({pixel_color, dest_address, dest_y, dest_x});

endmodule
